### src/isometric_vertex_rotate_project_defines.svh
// Assertion macros shared by the isometric rotate and project RTL.
// Included by every module that carries concurrent assertions.
`ifndef ISOMETRIC_VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define ISOMETRIC_VERTEX_ROTATE_PROJECT_DEFINES_SVH

`ifndef SYNTHESIS
`define ISOVR_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isovr assertion failed");
`define ISOVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isovr assertion failed");
`else
`define ISOVR_ASSERT(label, clk, rst, ante, cons)
`define ISOVR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### src/isovr_pkg.sv
// Package for the isometric rotate and project block: widths, constants,
// register indexes, control structs and the output saturation function.
`timescale 1ns / 1ps
`default_nettype none

package isovr_pkg;

  localparam int COORD_W    = 16;
  localparam int TRIG_FRAC  = 14;
  localparam int TRIG_W     = TRIG_FRAC + 2;
  localparam int OUT_W      = COORD_W + 3;
  localparam int CFG_DATA_W = (COORD_W > TRIG_W) ? COORD_W : TRIG_W;
  localparam int REG_IDX_W  = 3;
  localparam int NSTAGE     = 5;

  localparam int ISO_C_FRAC = 20;
  localparam int ISO_C_Q    = 908093;
  localparam int C_U_W      = ISO_C_FRAC;
  localparam int C_S_W      = ISO_C_FRAC + 1;

  // Intermediate widths
  localparam int RS_W    = COORD_W + 1;
  localparam int S_W     = COORD_W + 3;
  localparam int E_W     = COORD_W + 4;
  localparam int T_W     = COORD_W + 4;
  localparam int SC_W    = S_W + TRIG_W;
  localparam int EC_W    = E_W + TRIG_W;
  localparam int ACC_W   = EC_W;
  localparam int XLO_W   = ACC_W / 2;
  localparam int XHI_W   = ACC_W - XLO_W;
  localparam int XLO_P_W = XLO_W + C_U_W;
  localparam int XHI_P_W = XHI_W + C_S_W;
  localparam int XF_W    = ACC_W + C_S_W;
  localparam int SX_SH   = TRIG_FRAC + ISO_C_FRAC;
  localparam int SY_SH   = TRIG_FRAC + 1;
  localparam int YS_W    = ACC_W + 1;
  localparam int SAT_IN_W = XF_W - SX_SH;

  localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_W - 1));

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_PIVOT_X  = 3'd3,
    REG_PIVOT_Y  = 3'd4,
    REG_PIVOT_Z  = 3'd5,
    REG_COS_ROT  = 3'd6,
    REG_SIN_ROT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic signed [COORD_W-1:0] offset_z;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [COORD_W-1:0] pivot_z;
    logic signed [TRIG_W-1:0]  cos_rot;
    logic signed [TRIG_W-1:0]  sin_rot;
  } cfg_t;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } pipe_ctl_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(OUT_MAX);
    lo = SAT_IN_W'(OUT_MIN);
    if (v > hi) begin
      sat_out = hi[OUT_W-1:0];
    end else if (v < lo) begin
      sat_out = lo[OUT_W-1:0];
    end else begin
      sat_out = v[OUT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### src/isovr_if.sv
// Valid/ready channel interfaces: one triangle of vertices in, three
// screen points out. Depends on isovr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface isovr_tri_if import isovr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] a_x;
  logic signed [COORD_W-1:0] a_y;
  logic signed [COORD_W-1:0] a_z;
  logic signed [COORD_W-1:0] b_x;
  logic signed [COORD_W-1:0] b_y;
  logic signed [COORD_W-1:0] b_z;
  logic signed [COORD_W-1:0] c_x;
  logic signed [COORD_W-1:0] c_y;
  logic signed [COORD_W-1:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface isovr_scr_if import isovr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] a_screen_x;
  logic signed [OUT_W-1:0] a_screen_y;
  logic signed [OUT_W-1:0] b_screen_x;
  logic signed [OUT_W-1:0] b_screen_y;
  logic signed [OUT_W-1:0] c_screen_x;
  logic signed [OUT_W-1:0] c_screen_y;

  modport source (output valid, a_screen_x, a_screen_y, b_screen_x, b_screen_y,
                  c_screen_x, c_screen_y, input ready);
  modport sink (input valid, a_screen_x, a_screen_y, b_screen_x, b_screen_y,
                c_screen_x, c_screen_y, output ready);
endinterface

`default_nettype wire

### src/isovr_cfg.sv
// Configuration register bank: offsets, pivot and rotation cos/sin.
// Depends on isovr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isovr_cfg import isovr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [REG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.offset_x <= '0;
      regs.offset_y <= '0;
      regs.offset_z <= '0;
      regs.pivot_x  <= '0;
      regs.pivot_y  <= '0;
      regs.pivot_z  <= '0;
      regs.cos_rot  <= TRIG_W'(2 ** TRIG_FRAC);
      regs.sin_rot  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_OFFSET_X: regs.offset_x <= wr_data[COORD_W-1:0];
        REG_OFFSET_Y: regs.offset_y <= wr_data[COORD_W-1:0];
        REG_OFFSET_Z: regs.offset_z <= wr_data[COORD_W-1:0];
        REG_PIVOT_X:  regs.pivot_x  <= wr_data[COORD_W-1:0];
        REG_PIVOT_Y:  regs.pivot_y  <= wr_data[COORD_W-1:0];
        REG_PIVOT_Z:  regs.pivot_z  <= wr_data[COORD_W-1:0];
        REG_COS_ROT:  regs.cos_rot  <= wr_data[TRIG_W-1:0];
        REG_SIN_ROT:  regs.sin_rot  <= wr_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

### src/isovr_ctrl.sv
// Pipeline flow control: per-stage valid bits and load enables shared by
// all vertex lanes. Depends on isovr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "isometric_vertex_rotate_project_defines.svh"

module isovr_ctrl import isovr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output pipe_ctl_t ctl
);

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] valid_next;
  logic [NSTAGE:0]   rdy;

  always_comb begin
    rdy[NSTAGE] = out_ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
    ctl.load[0] = in_valid && rdy[0];
    for (int k = 1; k < NSTAGE; k++) begin
      ctl.load[k] = valid[k-1] && rdy[k];
    end
    for (int k = 0; k < NSTAGE; k++) begin
      valid_next[k] = ctl.load[k] || (valid[k] && !rdy[k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid[NSTAGE-1];

  `ISOVR_ASSERT(a_stall_only_when_full, clk, rst, !in_ready, &valid)
  `ISOVR_ASSERT_NEXT(a_take_enters_first, clk, rst, in_valid && in_ready, valid[0])
  `ISOVR_ASSERT_NEXT(a_items_conserved, clk, rst, 1'b1, $countones(valid) == $past($countones(valid)) + $past(in_valid && in_ready) - $past(out_valid && out_ready))

endmodule

`default_nettype wire

### src/isovr_lane.sv
// One vertex lane: offset, isometric projection and rotation about the
// pivot in five stages, ending in the output register. Depends on isovr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isovr_lane import isovr_pkg::*; (
  input  wire logic                      clk,
  input  wire cfg_t                      cfg,
  input  wire pipe_ctl_t                 ctl,
  input  wire logic signed [COORD_W-1:0] vx,
  input  wire logic signed [COORD_W-1:0] vy,
  input  wire logic signed [COORD_W-1:0] vz,
  output logic signed [OUT_W-1:0]        screen_x,
  output logic signed [OUT_W-1:0]        screen_y
);

  localparam logic        [C_U_W-1:0] C_U = C_U_W'(ISO_C_Q);
  localparam logic signed [C_S_W-1:0] C_S = C_S_W'(ISO_C_Q);

  // Stage 1: sums and differences
  logic signed [RS_W-1:0] px, py, rsum, rdif, oz_rz;
  logic signed [S_W-1:0]  s_val;
  logic signed [E_W-1:0]  e_val;
  logic signed [T_W-1:0]  t_val;

  assign px    = RS_W'(vx) + RS_W'(cfg.offset_x);
  assign py    = RS_W'(vy) + RS_W'(cfg.offset_y);
  assign rsum  = RS_W'(cfg.pivot_x) + RS_W'(cfg.pivot_y);
  assign rdif  = RS_W'(cfg.pivot_x) - RS_W'(cfg.pivot_y);
  assign oz_rz = RS_W'(cfg.offset_z) + RS_W'(cfg.pivot_z);
  assign s_val = S_W'(px) + S_W'(py) - S_W'(rsum);
  assign e_val = E_W'(px) - E_W'(py) - E_W'(rdif) - (E_W'(oz_rz) <<< 1);
  assign t_val = T_W'(rdif) + (T_W'(cfg.pivot_z) <<< 1) - (T_W'(vz) <<< 1);

  logic signed [S_W-1:0]  s1_s;
  logic signed [E_W-1:0]  s1_e;
  logic signed [T_W-1:0]  s1_t;
  logic signed [RS_W-1:0] s1_rsum;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_s    <= s_val;
      s1_e    <= e_val;
      s1_t    <= t_val;
      s1_rsum <= rsum;
    end
  end

  // Stage 2: trig products
  logic signed [SC_W-1:0] sc, ss;
  logic signed [EC_W-1:0] ec, es;

  assign sc = s1_s * cfg.cos_rot;
  assign ss = s1_s * cfg.sin_rot;
  assign ec = s1_e * cfg.cos_rot;
  assign es = s1_e * cfg.sin_rot;

  logic signed [SC_W-1:0] s2_sc, s2_ss;
  logic signed [EC_W-1:0] s2_ec, s2_es;
  logic signed [T_W-1:0]  s2_t;
  logic signed [RS_W-1:0] s2_rsum;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_sc   <= sc;
      s2_ss   <= ss;
      s2_ec   <= ec;
      s2_es   <= es;
      s2_t    <= s1_t;
      s2_rsum <= s1_rsum;
    end
  end

  // Stage 3: rotated numerators
  logic signed [ACC_W-1:0] xn, yn;

  assign xn = (ACC_W'(s2_rsum) <<< TRIG_FRAC) + ACC_W'(s2_sc) + ACC_W'(s2_es);
  assign yn = (ACC_W'(s2_t) <<< TRIG_FRAC) + ACC_W'(s2_ec) - ACC_W'(s2_ss);

  logic signed [ACC_W-1:0] s3_xn, s3_yn;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_xn <= xn;
      s3_yn <= yn;
    end
  end

  // Stage 4: split scale by cos 30 into two partial products; round and saturate screen y
  logic        [XLO_P_W-1:0] xlo;
  logic signed [XHI_P_W-1:0] xhi;
  logic signed [YS_W-1:0]    ysum;
  logic signed [OUT_W-1:0]   sy;

  assign xlo  = s3_xn[XLO_W-1:0] * C_U;
  assign xhi  = $signed(s3_xn[ACC_W-1:XLO_W]) * C_S;
  assign ysum = YS_W'(s3_yn) + (YS_W'(1) <<< (SY_SH - 1));
  assign sy   = sat_out(SAT_IN_W'($signed(ysum[YS_W-1:SY_SH])));

  logic        [XLO_P_W-1:0] s4_xlo;
  logic signed [XHI_P_W-1:0] s4_xhi;
  logic signed [OUT_W-1:0]   s4_sy;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_xlo <= xlo;
      s4_xhi <= xhi;
      s4_sy  <= sy;
    end
  end

  // Stage 5: recombine, round and saturate screen x
  logic signed [XF_W-1:0]  xfull;
  logic signed [OUT_W-1:0] sx;

  assign xfull = (XF_W'(s4_xhi) <<< XLO_W) + XF_W'(s4_xlo)
               + (XF_W'(1) <<< (SX_SH - 1));
  assign sx    = sat_out($signed(xfull[XF_W-1:SX_SH]));

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      screen_x <= sx;
      screen_y <= s4_sy;
    end
  end

endmodule

`default_nettype wire

### src/isometric_vertex_rotate_project.sv
// Top level of the isometric rotate and project block: config bank, flow
// control and three vertex lanes. Depends on isovr_pkg, isovr_if and submodules.
//
// Takes one triangle per transaction and returns its three screen points.
// Sustained rate is one triangle per clock unless the output stalls; the
// five-stage lane pipeline is add, trig multiply, sum, split cos-30 multiply,
// recombine and saturate. The three vertices run in three lanes side by side
// under one shared valid/ready pipeline, so a stalled output holds its result
// while bubbles in earlier stages still fill. The user must write registers
// via wr_en/wr_index/wr_data only while the block is empty; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module isometric_vertex_rotate_project import isovr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  isovr_tri_if.sink                  vertices,
  isovr_scr_if.source                screen,
  input  wire logic                  wr_en,
  input  wire logic [REG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data
);

  cfg_t      cfg;
  pipe_ctl_t ctl;

  isovr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  isovr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertices.valid),
    .in_ready  (vertices.ready),
    .out_valid (screen.valid),
    .out_ready (screen.ready),
    .ctl       (ctl)
  );

  isovr_lane u_lane_a (
    .clk      (clk),
    .cfg      (cfg),
    .ctl      (ctl),
    .vx       (vertices.a_x),
    .vy       (vertices.a_y),
    .vz       (vertices.a_z),
    .screen_x (screen.a_screen_x),
    .screen_y (screen.a_screen_y)
  );

  isovr_lane u_lane_b (
    .clk      (clk),
    .cfg      (cfg),
    .ctl      (ctl),
    .vx       (vertices.b_x),
    .vy       (vertices.b_y),
    .vz       (vertices.b_z),
    .screen_x (screen.b_screen_x),
    .screen_y (screen.b_screen_y)
  );

  isovr_lane u_lane_c (
    .clk      (clk),
    .cfg      (cfg),
    .ctl      (ctl),
    .vx       (vertices.c_x),
    .vy       (vertices.c_y),
    .vz       (vertices.c_z),
    .screen_x (screen.c_screen_x),
    .screen_y (screen.c_screen_y)
  );

endmodule

`default_nettype wire

### dv/isometric_vertex_rotate_project_tb.sv
`timescale 1ns / 1ps
// Testbench for isometric_vertex_rotate_project: edge-case and random triangles
// under random flow control, checked against an in-bench fixed-point projection.
// Depends on isovr_pkg, isovr_if and the RTL of the block.

module isometric_vertex_rotate_project_tb;
  import isovr_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OUT_W-1:0] scr_t;

  typedef struct packed {
    coord_t a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  } triangle_t;

  typedef struct packed {
    scr_t a_sx, a_sy, b_sx, b_sy, c_sx, c_sy;
  } points_t;

  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS  = 2_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  isovr_tri_if tris ();
  isovr_scr_if scr ();

  isometric_vertex_rotate_project DUT (
    .clk      (clk),
    .rst      (rst),
    .vertices (tris),
    .screen   (scr),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  cfg_t      cfg_model;
  triangle_t sent_tri = '0;
  triangle_t pending_tris[$];
  points_t   due_points[$];
  int        tris_queued   = 0;
  int        tris_accepted = 0;
  int        points_seen   = 0;
  int        fault_count   = 0;
  int        mismatch_count = 0;
  int        send_gap      = 0;
  int        stall_left    = 0;
  int        hold_left     = 0;
  bit        long_hold_done = 1'b0;
  bit        tri_taken     = 1'b0;
  bit        no_idle       = 1'b0;

  assign tris.a_x = sent_tri.a_x;
  assign tris.a_y = sent_tri.a_y;
  assign tris.a_z = sent_tri.a_z;
  assign tris.b_x = sent_tri.b_x;
  assign tris.b_y = sent_tri.b_y;
  assign tris.b_z = sent_tri.b_z;
  assign tris.c_x = sent_tri.c_x;
  assign tris.c_y = sent_tri.c_y;
  assign tris.c_z = sent_tri.c_z;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("isometric_vertex_rotate_project test failed");
    $finish;
  end

  function automatic scr_t round_sat(longint v, int sh);
    longint r;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > OUT_MAX) return scr_t'(OUT_MAX);
    if (r < OUT_MIN) return scr_t'(OUT_MIN);
    return scr_t'(r);
  endfunction

  function automatic void project_vertex(input coord_t vx, input coord_t vy, input coord_t vz,
                                         output scr_t sx, output scr_t sy);
    longint px, py, oz, rx, ry, rz, cs, sn, rsum, rdif, s, e, xn, yn;
    px   = longint'(vx) + longint'($signed(cfg_model.offset_x));
    py   = longint'(vy) + longint'($signed(cfg_model.offset_y));
    oz   = longint'($signed(cfg_model.offset_z));
    rx   = longint'($signed(cfg_model.pivot_x));
    ry   = longint'($signed(cfg_model.pivot_y));
    rz   = longint'($signed(cfg_model.pivot_z));
    cs   = longint'($signed(cfg_model.cos_rot));
    sn   = longint'($signed(cfg_model.sin_rot));
    rsum = rx + ry;
    rdif = rx - ry;
    s    = (px + py) - rsum;
    e    = (px - py) - rdif - 2 * (oz + rz);
    xn   = (rsum <<< TRIG_FRAC) + s * cs + e * sn;
    yn   = ((rdif + 2 * rz - 2 * longint'(vz)) <<< TRIG_FRAC) + e * cs - s * sn;
    sx   = round_sat(xn * longint'(ISO_C_Q), TRIG_FRAC + ISO_C_FRAC);
    sy   = round_sat(yn, TRIG_FRAC + 1);
  endfunction

  function automatic points_t project_triangle(triangle_t t);
    points_t p;
    project_vertex(t.a_x, t.a_y, t.a_z, p.a_sx, p.a_sy);
    project_vertex(t.b_x, t.b_y, t.b_z, p.b_sx, p.b_sy);
    project_vertex(t.c_x, t.c_y, t.c_z, p.c_sx, p.c_sy);
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r < 6) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    t = '{pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
          pick_coord(), pick_coord(), pick_coord(), pick_coord()};
    return t;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    real  ang;
    int   mode;
    c.offset_x = pick_coord();
    c.offset_y = pick_coord();
    c.offset_z = pick_coord();
    c.pivot_x  = pick_coord();
    c.pivot_y  = pick_coord();
    c.pivot_z  = pick_coord();
    mode = $urandom_range(0, 3);
    if (mode == 1) begin
      c.cos_rot = coord_t'(int'($urandom_range(0, 32768)) - 16384);
      c.sin_rot = coord_t'(int'($urandom_range(0, 32768)) - 16384);
    end else if (mode == 2) begin
      c.cos_rot = coord_t'((int'($urandom_range(0, 2)) - 1) * 16384);
      c.sin_rot = coord_t'((int'($urandom_range(0, 2)) - 1) * 16384);
    end else begin
      ang = real'($urandom_range(0, 359)) * 3.14159265358979 / 180.0;
      c.cos_rot = coord_t'($rtoi($cos(ang) * 16384.0));
      c.sin_rot = coord_t'($rtoi($sin(ang) * 16384.0));
    end
    return c;
  endfunction

  task automatic check_field(string name, scr_t got, scr_t want);
    if (got !== want) begin
      fault_count++;
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s of result %0d: expected %0d, got %0d",
                 name, points_seen, want, got);
    end
  endtask

  // Sender: hold the triangle until it is taken, then idle or advance.
  always @(negedge clk) begin
    if (rst) begin
      tris.valid <= 1'b0;
    end else if (!tris.valid || tri_taken) begin
      tri_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        tris.valid <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        sent_tri   <= pending_tris.pop_front();
        tris.valid <= 1'b1;
        send_gap   = pick_gap();
      end else begin
        tris.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the pipeline up.
  always @(negedge clk) begin
    if (rst) begin
      scr.ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        scr.ready <= 1'b0;
      end else if (!long_hold_done && points_seen >= HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = HOLD_CYCLES;
        scr.ready      <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        scr.ready <= 1'b0;
      end else begin
        scr.ready  <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    points_t got;
    points_t want;
    if (!rst) begin
      if (tris.valid && tris.ready) begin
        due_points.push_back(project_triangle(sent_tri));
        tris_accepted++;
        tri_taken = 1'b1;
      end
      if (scr.valid && scr.ready) begin
        got = '{scr.a_screen_x, scr.a_screen_y, scr.b_screen_x, scr.b_screen_y,
                scr.c_screen_x, scr.c_screen_y};
        if (due_points.size() == 0) begin
          fault_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %0d: %0d %0d %0d %0d %0d %0d", points_seen,
                     got.a_sx, got.a_sy, got.b_sx, got.b_sy, got.c_sx, got.c_sy);
        end else begin
          want = due_points.pop_front();
          check_field("a_screen_x", got.a_sx, want.a_sx);
          check_field("a_screen_y", got.a_sy, want.a_sy);
          check_field("b_screen_x", got.b_sx, want.b_sx);
          check_field("b_screen_y", got.b_sy, want.b_sy);
          check_field("c_screen_x", got.c_sx, want.c_sx);
          check_field("c_screen_y", got.c_sy, want.c_sy);
        end
        points_seen++;
      end
    end
  end

  task automatic enqueue(triangle_t t);
    pending_tris.push_back(t);
    tris_queued++;
  endtask

  task automatic queue_edge_triangles();
    enqueue('{default: 16'sd0});
    enqueue('{default: 16'sh7fff});
    enqueue('{default: 16'sh8000});
    enqueue('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh8000, 16'sh7fff, 16'sh0001});
    enqueue(random_triangle());
  endtask

  task automatic drain();
    while (tris_accepted != tris_queued || due_points.size() != 0) @(negedge clk);
    repeat (NSTAGE + 2) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    case (idx)
      REG_OFFSET_X: cfg_model.offset_x = value[COORD_W-1:0];
      REG_OFFSET_Y: cfg_model.offset_y = value[COORD_W-1:0];
      REG_OFFSET_Z: cfg_model.offset_z = value[COORD_W-1:0];
      REG_PIVOT_X:  cfg_model.pivot_x  = value[COORD_W-1:0];
      REG_PIVOT_Y:  cfg_model.pivot_y  = value[COORD_W-1:0];
      REG_PIVOT_Z:  cfg_model.pivot_z  = value[COORD_W-1:0];
      REG_COS_ROT:  cfg_model.cos_rot  = value[TRIG_W-1:0];
      REG_SIN_ROT:  cfg_model.sin_rot  = value[TRIG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(cfg_t c);
    write_reg(REG_OFFSET_X, c.offset_x);
    write_reg(REG_OFFSET_Y, c.offset_y);
    write_reg(REG_OFFSET_Z, c.offset_z);
    write_reg(REG_PIVOT_X, c.pivot_x);
    write_reg(REG_PIVOT_Y, c.pivot_y);
    write_reg(REG_PIVOT_Z, c.pivot_z);
    write_reg(REG_COS_ROT, c.cos_rot);
    write_reg(REG_SIN_ROT, c.sin_rot);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin
    cfg_t c;
    wr_en      = 1'b0;
    wr_index   = REG_OFFSET_X;
    wr_data    = '0;
    cfg_model  = '0;
    cfg_model.cos_rot = 16'sd16384;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings first, then the register extremes and a mixed set.
    queue_edge_triangles();
    drain();
    c = '{offset_x: 16'sh7fff, offset_y: 16'sh7fff, offset_z: 16'sh7fff,
          pivot_x: 16'sh8000, pivot_y: 16'sh8000, pivot_z: 16'sh8000,
          cos_rot: 16'sd16384, sin_rot: 16'sd16384};
    load_settings(c);
    queue_edge_triangles();
    drain();
    c = '{offset_x: 16'sh8000, offset_y: 16'sh8000, offset_z: 16'sh8000,
          pivot_x: 16'sh7fff, pivot_y: 16'sh7fff, pivot_z: 16'sh7fff,
          cos_rot: -16'sd16384, sin_rot: -16'sd16384};
    load_settings(c);
    queue_edge_triangles();
    drain();
    c = '{offset_x: 16'sd100, offset_y: -16'sd37, offset_z: 16'sd5,
          pivot_x: -16'sd250, pivot_y: 16'sd64, pivot_z: -16'sd3,
          cos_rot: 16'sd0, sin_rot: -16'sd16384};
    load_settings(c);
    queue_edge_triangles();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      load_settings(random_settings());
      no_idle = (ph % 3 == 1);
      repeat (PHASE_ITEMS) enqueue(random_triangle());
      drain();
    end

    repeat (NSTAGE * 4) @(posedge clk);
    fault_count += due_points.size();
    if (fault_count == 0) begin
      $display("isometric_vertex_rotate_project test passed");
    end else begin
      $display("isometric_vertex_rotate_project test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/isovr_pkg.sv
src/isovr_if.sv
src/isovr_cfg.sv
src/isovr_ctrl.sv
src/isovr_lane.sv
src/isometric_vertex_rotate_project.sv
dv/isometric_vertex_rotate_project_tb.sv
